[src/sccl_pkg.sv]
// shared constants, codes and control structs of the sector cache tag engine
package sccl_pkg;

  localparam int ENTRIES     = 64;
  localparam int MAX_RESULTS = 64;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int TAG_W       = 32;
  localparam int ENTRY_W     = 6;
  localparam int OP_W        = 2;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  // source of the working entry register
  typedef enum logic [2:0] {
    ENT_HOLD,
    ENT_CMP,
    ENT_FREE,
    ENT_IDX,
    ENT_ZERO
  } ent_sel_e;

  typedef struct packed {
    logic     start;
    logic     idx_clr;
    logic     idx_inc;
    logic     look_issue;
    logic     rd_ent;
    logic     clr_ref;
    ent_sel_e ent_sel;
    logic     push_hit;
    logic     push_fill;
    logic     push_pend;
    logic     pend_last;
    logic     pend_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic free_fnd;
    logic idx_last;
    logic ref_idx;
    logic cand_idx;
    logic ent_last;
    logic cnt_last;
    logic pend_vld;
    logic out_busy;
  } st_t;

endpackage

[src/sccl_ram.sv]
// generic single-write, single-read ram with registered read data
module sccl_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/sccl_dp.sv]
// datapath: entry flags, tag ram, scan index, flush pending word and output register
module sccl_dp import sccl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [TAG_W-1:0]   sector_i,
  input  cmd_t               cmd_i,
  output st_t                st_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               hit_o,
  output logic [ENTRY_W-1:0] entry_o,
  output logic               fill_needed_o,
  output logic               writeback_o,
  output logic [TAG_W-1:0]   writeback_sector_o,
  output logic               last_o
);

  logic               op_wr_q;
  logic [TAG_W-1:0]   sector_q;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   ent_q, ent_d;
  logic               cmp_vld_q;
  logic [IDX_W-1:0]   cmp_idx_q;
  logic               free_fnd_q, free_fnd_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic [ENTRIES-1:0] free_q, free_d;
  logic [ENTRIES-1:0] dirty_q, dirty_d;
  logic [ENTRIES-1:0] ref_q, ref_d;
  logic               pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]   pend_ent_q;
  logic [TAG_W-1:0]   pend_tag_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               hit_q, fill_q, wb_q, last_q;
  logic [ENTRY_W-1:0] entry_q;
  logic [TAG_W-1:0]   wbsec_q;
  logic [IDX_W-1:0]   raddr;
  logic [TAG_W-1:0]   rdata;
  logic               push;

  assign raddr = cmd_i.rd_ent ? ent_q : idx_q;

  sccl_ram #(
    .Width(TAG_W),
    .Depth(ENTRIES)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push_fill),
    .waddr_i(ent_q),
    .wdata_i(sector_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign push = cmd_i.push_hit | cmd_i.push_fill | cmd_i.push_pend;

  // status towards the controller
  assign st_o.hit      = cmp_vld_q & ~free_q[cmp_idx_q] & (rdata == sector_q);
  assign st_o.free_fnd = free_fnd_q;
  assign st_o.idx_last = (idx_q == IDX_W'(ENTRIES - 1));
  assign st_o.ref_idx  = ref_q[idx_q];
  assign st_o.cand_idx = dirty_q[idx_q] & ~free_q[idx_q];
  assign st_o.ent_last = (ent_q == IDX_W'(ENTRIES - 1));
  assign st_o.cnt_last = (cnt_q == CNT_W'(MAX_RESULTS - 1));
  assign st_o.pend_vld = pend_vld_q;
  assign st_o.out_busy = out_valid_q & ~out_ready_i;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start || cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_comb begin
    unique case (cmd_i.ent_sel)
      ENT_HOLD: ent_d = ent_q;
      ENT_CMP:  ent_d = cmp_idx_q;
      ENT_FREE: ent_d = free_idx_q;
      ENT_IDX:  ent_d = idx_q;
      ENT_ZERO: ent_d = '0;
      default:  ent_d = ent_q;
    endcase
  end

  // lowest free entry seen during the lookup scan
  always_comb begin
    free_fnd_d = free_fnd_q;
    free_idx_d = free_idx_q;
    if (cmd_i.start) begin
      free_fnd_d = 1'b0;
    end else if (cmd_i.look_issue && free_q[idx_q] && !free_fnd_q) begin
      free_fnd_d = 1'b1;
      free_idx_d = idx_q;
    end
  end

  always_comb begin
    free_d = free_q;
    dirty_d = dirty_q;
    ref_d = ref_q;
    if (cmd_i.clr_ref) begin
      ref_d[idx_q] = 1'b0;
    end
    if (cmd_i.pend_load) begin
      dirty_d[ent_q] = 1'b0;
    end
    if (cmd_i.push_hit) begin
      ref_d[ent_q] = 1'b1;
      if (op_wr_q) begin
        dirty_d[ent_q] = 1'b1;
      end
    end
    if (cmd_i.push_fill) begin
      free_d[ent_q] = 1'b0;
      ref_d[ent_q] = 1'b1;
      dirty_d[ent_q] = op_wr_q;
    end
  end

  always_comb begin
    pend_vld_d = pend_vld_q;
    cnt_d = cnt_q;
    if (cmd_i.start) begin
      pend_vld_d = 1'b0;
      cnt_d = '0;
    end else if (cmd_i.pend_load) begin
      pend_vld_d = 1'b1;
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.push_pend) begin
      pend_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cmp_vld_q <= 1'b0;
      free_fnd_q <= 1'b0;
      free_q <= '1;
      dirty_q <= '0;
      ref_q <= '0;
      pend_vld_q <= 1'b0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      cmp_vld_q <= cmd_i.look_issue;
      free_fnd_q <= free_fnd_d;
      free_q <= free_d;
      dirty_q <= dirty_d;
      ref_q <= ref_d;
      pend_vld_q <= pend_vld_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_wr_q <= (operation_i == OP_WRITE);
      sector_q <= sector_i;
    end
    ent_q <= ent_d;
    cmp_idx_q <= idx_q;
    free_idx_q <= free_idx_d;
    if (cmd_i.pend_load) begin
      pend_ent_q <= ent_q;
      pend_tag_q <= rdata;
    end
    if (cmd_i.push_hit) begin
      hit_q <= 1'b1;
      entry_q <= ENTRY_W'(ent_q);
      fill_q <= 1'b0;
      wb_q <= 1'b0;
      wbsec_q <= '0;
      last_q <= 1'b1;
    end else if (cmd_i.push_fill) begin
      hit_q <= 1'b0;
      entry_q <= ENTRY_W'(ent_q);
      fill_q <= 1'b1;
      wb_q <= dirty_q[ent_q];
      wbsec_q <= dirty_q[ent_q] ? rdata : '0;
      last_q <= 1'b1;
    end else if (cmd_i.push_pend) begin
      hit_q <= 1'b0;
      entry_q <= ENTRY_W'(pend_ent_q);
      fill_q <= 1'b0;
      wb_q <= 1'b1;
      wbsec_q <= pend_tag_q;
      last_q <= cmd_i.pend_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign hit_o              = hit_q;
  assign entry_o            = entry_q;
  assign fill_needed_o      = fill_q;
  assign writeback_o        = wb_q;
  assign writeback_sector_o = wbsec_q;
  assign last_o             = last_q;

endmodule

[src/sccl_ctrl.sv]
// controller: sequences lookup, victim sweep, fill and flush scans
module sccl_ctrl import sccl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] operation_i,
  output logic            in_ready_o,
  input  st_t             st_i,
  output cmd_t            cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_LTAIL,
    S_HIT,
    S_SWEEP,
    S_VCHK,
    S_FILL,
    S_FSCAN,
    S_FGOT,
    S_FEND
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;
  logic   accept;

  assign accept = in_valid_i & in_ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.ent_sel = ENT_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.start = 1'b1;
          if (operation_i == OP_READ || operation_i == OP_WRITE) begin
            state_d = S_LOOK;
          end else if (operation_i == OP_FLUSH) begin
            state_d = S_FSCAN;
          end
        end
      end
      S_LOOK: begin
        cmd_o.look_issue = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (st_i.hit) begin
          cmd_o.ent_sel = ENT_CMP;
          state_d = S_HIT;
        end else if (st_i.idx_last) begin
          state_d = S_LTAIL;
        end
      end
      S_LTAIL: begin
        if (st_i.hit) begin
          cmd_o.ent_sel = ENT_CMP;
          state_d = S_HIT;
        end else if (st_i.free_fnd) begin
          cmd_o.ent_sel = ENT_FREE;
          state_d = S_VCHK;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d = S_SWEEP;
        end
      end
      S_HIT: begin
        if (!st_i.out_busy) begin
          cmd_o.push_hit = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (st_i.ref_idx) begin
          cmd_o.clr_ref = 1'b1;
          cmd_o.idx_inc = 1'b1;
          if (st_i.idx_last) begin
            cmd_o.ent_sel = ENT_ZERO;
            state_d = S_VCHK;
          end
        end else begin
          cmd_o.ent_sel = ENT_IDX;
          state_d = S_VCHK;
        end
      end
      S_VCHK: begin
        cmd_o.rd_ent = 1'b1;
        state_d = S_FILL;
      end
      S_FILL: begin
        cmd_o.rd_ent = 1'b1;
        if (!st_i.out_busy) begin
          cmd_o.push_fill = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FSCAN: begin
        if (st_i.cand_idx) begin
          cmd_o.ent_sel = ENT_IDX;
          state_d = S_FGOT;
        end else if (st_i.idx_last) begin
          state_d = S_FEND;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_FGOT: begin
        cmd_o.rd_ent = 1'b1;
        if (!st_i.pend_vld || !st_i.out_busy) begin
          cmd_o.push_pend = st_i.pend_vld;
          cmd_o.pend_load = 1'b1;
          if (st_i.cnt_last || st_i.ent_last) begin
            state_d = S_FEND;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d = S_FSCAN;
          end
        end
      end
      S_FEND: begin
        if (!st_i.pend_vld) begin
          state_d = S_IDLE;
        end else if (!st_i.out_busy) begin
          cmd_o.push_pend = 1'b1;
          cmd_o.pend_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      in_ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

[src/sector_cache_clock_tags_top.sv]
// top level of the sector cache tag and second-chance replacement engine
// usage:
// - request channel (in_valid_i / in_ready_o) carries one word: operation_i and sector_i
//   (read, write or flush; code 3 is swallowed with no effect)
// - result channel (out_valid_o / out_ready_i) gives one word per read or write, and one
//   word per dirty occupied entry on a flush, ascending, last_o on the final one
// - one request in flight at a time; the 64 tags live in a ram scanned one entry a cycle
//   through its registered read port, pausing at each dirty entry during a flush scan
// - hit on entry k: the lookup scan ends at the hit
// - miss into a free entry: the whole tag ram is scanned first
// - miss with all entries taken: plus a second-chance sweep to pick the victim
// - flush: a scan of every entry plus one result word per dirty entry,
//   no word if nothing dirty
// - the next request is taken as soon as the previous one has handed over its last word,
//   even while that word still sits in the output register
// - a stalled receiver freezes the engine at its next result; nothing is dropped
// - reset marks every entry free, clean and unreferenced; tags need no clearing
module sector_cache_clock_tags_top import sccl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [TAG_W-1:0]   sector_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [ENTRY_W-1:0] entry_o,
  output logic               fill_needed_o,
  output logic               writeback_o,
  output logic [TAG_W-1:0]   writeback_sector_o,
  output logic               last_o
);

  cmd_t cmd;
  st_t  st;

  // state machine
  sccl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .operation_i(operation_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // flags, tag ram and output register
  sccl_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .operation_i       (operation_i),
    .sector_i          (sector_i),
    .cmd_i             (cmd),
    .st_o              (st),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .hit_o             (hit_o),
    .entry_o           (entry_o),
    .fill_needed_o     (fill_needed_o),
    .writeback_o       (writeback_o),
    .writeback_sector_o(writeback_sector_o),
    .last_o            (last_o)
  );

endmodule

[src/sccl_chk.sv]
// port-level checker of the sector cache tag engine, with its bind
module sccl_chk import sccl_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               hit_o,
  input logic [ENTRY_W-1:0] entry_o,
  input logic               fill_needed_o,
  input logic               writeback_o,
  input logic [TAG_W-1:0]   writeback_sector_o,
  input logic               last_o
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(entry_o) &&
      $stable(writeback_sector_o) && $stable(last_o))
    else $error("result word changed while stalled");

  // a hit never needs disk traffic
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !fill_needed_o && !writeback_o && last_o)
    else $error("hit word carries fill or writeback");

  // a fill closes its request
  a_fill_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fill_needed_o |-> !hit_o && last_o)
    else $error("fill word not final or marked hit");

  // sector field is zero without writeback
  a_wbsec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !writeback_o |-> writeback_sector_o == '0)
    else $error("writeback sector set without writeback");

  // only flush words can be non-final
  a_nonlast_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> writeback_o && !hit_o && !fill_needed_o)
    else $error("non-final word is not a flush writeback");

endmodule

bind sector_cache_clock_tags_top sccl_chk u_sccl_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .hit_o             (hit_o),
  .entry_o           (entry_o),
  .fill_needed_o     (fill_needed_o),
  .writeback_o       (writeback_o),
  .writeback_sector_o(writeback_sector_o),
  .last_o            (last_o)
);
